>>> hw/rtl/button_debounce_press_hold_unit_macros.svh
// Assertion helpers for the top-level file, which checks its own logic.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef BUTTON_DEBOUNCE_PRESS_HOLD_UNIT_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_HOLD_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDPH_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDPH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/bdph_pkg.sv
package bdph_pkg;

	// Widths of the item fields and of the configuration port.
	localparam int SENSE_W    = 2;
	localparam int IDX_W      = 1;
	localparam int FLAG_W     = 2;
	localparam int TIMER_W    = 16;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;

	localparam int NUM_BUTTONS_DEF = 2;

	// Configuration register reset values.
	localparam logic [TIMER_W-1:0] HOLD_TIME_RST  = 16'd1000;
	localparam logic [TIMER_W-1:0] TICK_STEP_RST  = 16'd10;
	localparam logic [TIMER_W-1:0] PRESS_TIME_RST = 16'd50;

	// Register indexes, taken from paddr[3:2].
	localparam logic [1:0] REG_HOLD_TIME  = 2'd0;
	localparam logic [1:0] REG_TICK_STEP  = 2'd1;
	localparam logic [1:0] REG_PRESS_TIME = 2'd2;

	typedef enum logic [1:0] {
		MODE_TICK       = 2'd0,
		MODE_READ_PRESS = 2'd1,
		MODE_READ_HELD  = 2'd2
	} mode_t;

	// Command handed to every lane for one transaction.
	typedef struct packed {
		logic  fire;
		mode_t mode;
		logic  level;
		logic  sel;
	} lane_cmd_t;

	// What a lane reports: flags after the step, its read answer, and current state.
	typedef struct packed {
		logic held;
		logic pressed;
		logic result;
		logic held_q;
		logic pressed_q;
		logic ack_q;
	} lane_stat_t;

	typedef struct packed {
		logic [FLAG_W-1:0] pressed_flags;
		logic [FLAG_W-1:0] held_flags;
		logic              result_bit;
	} out_item_t;

endpackage

>>> hw/rtl/bdph_lane.sv
// Per-button debounce core: timer, held, pressed and acknowledged state.
module bdph_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  bdph_pkg::lane_cmd_t               cmd,
	input  logic [bdph_pkg::TIMER_W-1:0]      hold_time,
	input  logic [bdph_pkg::TIMER_W-1:0]      tick_step,
	input  logic [bdph_pkg::TIMER_W-1:0]      press_time,
	output bdph_pkg::lane_stat_t              stat
);

	logic [bdph_pkg::TIMER_W-1:0] timer_q, timer_d, timer_sat;
	logic [bdph_pkg::TIMER_W:0]   grown;
	logic                         held_q, held_d;
	logic                         pressed_q, pressed_d;
	logic                         ack_q, ack_d;
	logic                         result;

	assign grown     = {1'b0, timer_q} + {1'b0, tick_step};
	assign timer_sat = grown[bdph_pkg::TIMER_W] ? '1 : grown[bdph_pkg::TIMER_W-1:0];

	always_comb begin
		timer_d   = timer_q;
		held_d    = held_q;
		pressed_d = pressed_q;
		ack_d     = ack_q;
		result    = 1'b0;
		case (cmd.mode)
			bdph_pkg::MODE_TICK: begin
				if (cmd.level) begin
					if (timer_q < hold_time) begin
						timer_d = timer_sat;
					end else begin
						held_d = 1'b1;
					end
					// The press test sees the timer after this tick's growth.
					if ((timer_d > press_time) && !ack_q) begin
						pressed_d = 1'b1;
					end
				end else begin
					timer_d = '0;
					held_d  = 1'b0;
					if (ack_q) begin
						pressed_d = 1'b0;
						ack_d     = 1'b0;
					end
				end
			end
			bdph_pkg::MODE_READ_PRESS: begin
				if (cmd.sel && pressed_q && !ack_q) begin
					result = 1'b1;
					ack_d  = 1'b1;
				end
			end
			bdph_pkg::MODE_READ_HELD: begin
				result = cmd.sel & held_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timer_q   <= '0;
			held_q    <= 1'b0;
			pressed_q <= 1'b0;
			ack_q     <= 1'b0;
		end else if (cmd.fire) begin
			timer_q   <= timer_d;
			held_q    <= held_d;
			pressed_q <= pressed_d;
			ack_q     <= ack_d;
		end
	end

	assign stat.held      = held_d;
	assign stat.pressed   = pressed_d;
	assign stat.result    = result;
	assign stat.held_q    = held_q;
	assign stat.pressed_q = pressed_q;
	assign stat.ack_q     = ack_q;

endmodule

>>> hw/rtl/bdph_merge.sv
// Combines the lane reports into one result item.
module bdph_merge #(
	parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
	input  bdph_pkg::lane_stat_t stat [NUM_BUTTONS],
	output bdph_pkg::out_item_t  item
);

	// Only the selected lane can answer, so an OR picks its answer.
	always_comb begin
		item.result_bit = 1'b0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			item.result_bit = item.result_bit | stat[i].result;
		end
	end

	for (genvar i = 0; i < bdph_pkg::FLAG_W; i++) begin : g_flag
		if (i < NUM_BUTTONS) begin : g_lane
			assign item.held_flags[i]    = stat[i].held;
			assign item.pressed_flags[i] = stat[i].pressed;
		end else begin : g_none
			assign item.held_flags[i]    = 1'b0;
			assign item.pressed_flags[i] = 1'b0;
		end
	end

endmodule

>>> hw/rtl/bdph_out_buf.sv
// Two-entry output buffer: an output register plus a skid register.
module bdph_out_buf (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  bdph_pkg::out_item_t in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output bdph_pkg::out_item_t out_item
);

	logic                out_valid_q, skid_valid_q;
	bdph_pkg::out_item_t out_item_q, skid_item_q;
	logic                out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= in_valid;
			end
		end else if (in_valid && in_ready) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_item_q <= skid_valid_q ? skid_item_q : in_item;
		end else if (in_valid && in_ready) begin
			skid_item_q <= in_item;
		end
	end

endmodule

>>> hw/rtl/button_debounce_press_hold_unit.sv
// Button debouncer with press latching and hold detection. Each input transaction is a tick
// (tuser mode 0) carrying the raw level of every button, a read press (mode 1) that reports an
// unacknowledged press of one button once and then acknowledges it, or a read held (mode 2).
// Mode 3 changes nothing and answers 0. Every input transaction gives exactly one output
// transaction with the read answer and the held and pressed flags after the step. One
// transaction is taken per clock: every button has its own lane that updates its state in
// the accepting cycle, and a two-entry output buffer (output plus skid register) lets input
// continue while a result waits, so the input stalls only once both entries are full. A
// result goes to the output register, or to the skid register while the output is held.
// Registers sit at byte addresses 0 (hold_time), 4 (tick_step) and 8 (press_time); the user
// must write them only while the block is idle, which the block itself does not enforce.
module button_debounce_press_hold_unit #(
	parameter int NUM_BUTTONS = bdph_pkg::NUM_BUTTONS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [bdph_pkg::CFG_ADDR_W-1:0]     paddr,
	input  logic [bdph_pkg::CFG_DATA_W-1:0]     pwdata,
	output logic [bdph_pkg::CFG_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // sense_bits[1:0], button_index[2]
	input  logic [1:0]                          s_axis_tuser,  // mode[1:0]
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [7:0]                          m_axis_tdata   // result_bit[0], held_flags[2:1],
	                                                           // pressed_flags[4:3]
);

	logic [bdph_pkg::TIMER_W-1:0] hold_time_q, tick_step_q, press_time_q;
	logic                         cfg_write;
	logic                         fire;
	logic                         button_index;
	bdph_pkg::mode_t              mode;
	bdph_pkg::lane_stat_t         lane_stat [NUM_BUTTONS];
	bdph_pkg::out_item_t          merged_item, out_item;

	// Configuration registers. pready is tied high, so a write lands on the access cycle.
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_time_q  <= bdph_pkg::HOLD_TIME_RST;
			tick_step_q  <= bdph_pkg::TICK_STEP_RST;
			press_time_q <= bdph_pkg::PRESS_TIME_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				bdph_pkg::REG_HOLD_TIME:  hold_time_q  <= pwdata[bdph_pkg::TIMER_W-1:0];
				bdph_pkg::REG_TICK_STEP:  tick_step_q  <= pwdata[bdph_pkg::TIMER_W-1:0];
				bdph_pkg::REG_PRESS_TIME: press_time_q <= pwdata[bdph_pkg::TIMER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			bdph_pkg::REG_HOLD_TIME:  prdata = {16'd0, hold_time_q};
			bdph_pkg::REG_TICK_STEP:  prdata = {16'd0, tick_step_q};
			bdph_pkg::REG_PRESS_TIME: prdata = {16'd0, press_time_q};
			default:                  prdata = '0;
		endcase
	end

	// Input decode. Every lane sees the same transaction.
	assign fire         = s_axis_tvalid && s_axis_tready;
	assign mode         = bdph_pkg::mode_t'(s_axis_tuser);
	assign button_index = s_axis_tdata[2];

	for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
		bdph_pkg::lane_cmd_t cmd;

		assign cmd.fire = fire;
		assign cmd.mode = mode;

		// Buttons above the sense field never see a level; buttons above the index
		// range can never be selected by a read.
		if (i < bdph_pkg::SENSE_W) begin : g_level
			assign cmd.level = s_axis_tdata[i];
		end else begin : g_nolevel
			assign cmd.level = 1'b0;
		end

		if (i < (1 << bdph_pkg::IDX_W)) begin : g_sel
			assign cmd.sel = (int'(button_index) == i);
		end else begin : g_nosel
			assign cmd.sel = 1'b0;
		end

		bdph_lane u_lane (
			.clk        (clk),
			.arst_n     (arst_n),
			.cmd        (cmd),
			.hold_time  (hold_time_q),
			.tick_step  (tick_step_q),
			.press_time (press_time_q),
			.stat       (lane_stat[i])
		);
	end

	bdph_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.stat (lane_stat),
		.item (merged_item)
	);

	bdph_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fire),
		.in_ready  (s_axis_tready),
		.in_item   (merged_item),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_item  (out_item)
	);

	assign m_axis_tdata = {3'b000, out_item.pressed_flags, out_item.held_flags,
		out_item.result_bit};

	// Checks on the lane state and the output buffer.
	`include "button_debounce_press_hold_unit_macros.svh"

	// An acknowledged press is always still latched.
	`BDPH_ASSERT_SAME(a_ack_implies_pressed, lane_stat[0].ack_q, lane_stat[0].pressed_q, "ack without press")
	// The input stalls only while a result is waiting on the output.
	`BDPH_ASSERT_SAME(a_stall_has_output, !s_axis_tready, m_axis_tvalid, "stall with empty output")
	// A read of the held flag leaves the pressed and held state alone.
	`BDPH_ASSERT_NEXT(a_read_held_quiet, fire && (mode == bdph_pkg::MODE_READ_HELD), $stable(lane_stat[0].pressed_q) && $stable(lane_stat[0].held_q), "read held changed state")

endmodule

>>> tb/tb_button_debounce_press_hold_unit.sv
// Testbench for the button debounce unit with press latching and hold detection.
// A behavioral copy of the debouncer runs beside the block: every input transaction that the
// block takes is stepped through that copy, and the flags it produces wait in a queue until the
// block hands out its result. Each output transaction is compared with the oldest entry, field
// by field. Configuration goes through the APB port while the stream is idle, and every write
// is read back.
module tb_button_debounce_press_hold_unit;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_BTN = bdph_pkg::NUM_BUTTONS_DEF;
	// Mode 3 is not a member of the package enum, so it gets a name of its own here.
	localparam logic [1:0] MODE_UNUSED = 2'd3;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [bdph_pkg::CFG_ADDR_W-1:0] paddr;
	logic [bdph_pkg::CFG_DATA_W-1:0] pwdata;
	logic [bdph_pkg::CFG_DATA_W-1:0] prdata;
	logic                            pready;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [7:0]                      s_axis_tdata;   // sense_bits[1:0], button_index[2]
	logic [1:0]                      s_axis_tuser;   // mode[1:0]
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [7:0]                      m_axis_tdata;   // result_bit[0], held_flags[2:1],
	                                                 // pressed_flags[4:3]

	button_debounce_press_hold_unit #(
		.NUM_BUTTONS(N_BTN)
	) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	// Shadow of the configuration registers and of the per-button state.
	logic [bdph_pkg::TIMER_W-1:0] cfg_hold_time;
	logic [bdph_pkg::TIMER_W-1:0] cfg_tick_step;
	logic [bdph_pkg::TIMER_W-1:0] cfg_press_time;
	logic [bdph_pkg::TIMER_W-1:0] btn_timer [N_BTN];
	logic                         btn_held  [N_BTN];
	logic                         btn_press [N_BTN];
	logic                         btn_acked [N_BTN];

	// Flags the block owes us, oldest first.
	bdph_pkg::out_item_t flags_due [$];

	int items_sent;
	int results_seen;
	int mismatch_count;

	// Knobs shared by the stimulus and the output-side driver.
	bit tx_idle_en;
	bit rx_idle_en;
	int rx_hold_request;

	// The clock runs free with an 8 ns period.
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Safety net: a correct run finishes far earlier than this.
	initial begin
		#2_000_000;
		$display("FAIL button_debounce_press_hold_unit");
		$finish;
	end

	// One step of the debouncer on the shadow state. A tick updates every button from its sensed
	// level; a read press reports an unacknowledged press once and acknowledges it; a read held
	// returns the held mark. Mode 3 touches nothing. The flags are taken after the update.
	function automatic bdph_pkg::out_item_t debounce_step(logic [1:0] mode, logic [1:0] sense,
		logic idx);
		bdph_pkg::out_item_t res;
		logic [16:0]         grown;
		res = '0;
		case (mode)
			bdph_pkg::MODE_TICK: begin
				for (int b = 0; b < N_BTN; b++) begin
					if (sense[b]) begin
						if (btn_timer[b] < cfg_hold_time) begin
							grown = {1'b0, btn_timer[b]} + {1'b0, cfg_tick_step};
							// The timer sticks at its top value instead of wrapping.
							btn_timer[b] = grown[16] ? 16'hFFFF : grown[15:0];
						end else begin
							btn_held[b] = 1'b1;
						end
						// The press test sees the timer after this tick's growth.
						if (btn_timer[b] > cfg_press_time && !btn_acked[b])
							btn_press[b] = 1'b1;
					end else begin
						btn_timer[b] = '0;
						btn_held[b]  = 1'b0;
						if (btn_acked[b]) begin
							btn_press[b] = 1'b0;
							btn_acked[b] = 1'b0;
						end
					end
				end
			end
			bdph_pkg::MODE_READ_PRESS: begin
				if (btn_press[idx] && !btn_acked[idx]) begin
					res.result_bit = 1'b1;
					btn_acked[idx] = 1'b1;
				end
			end
			bdph_pkg::MODE_READ_HELD: begin
				res.result_bit = btn_held[idx];
			end
			default: begin
			end
		endcase
		for (int b = 0; b < N_BTN; b++) begin
			res.held_flags[b]    = btn_held[b];
			res.pressed_flags[b] = btn_press[b];
		end
		return res;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at %0t: %s got %0d, expected %0d", $realtime, what, got, want);
		mismatch_count++;
	endtask

	// Watches both stream sides at every edge. An accepted input is predicted first, so a result
	// taken at the same edge always finds its expectation already queued.
	always @(posedge clk) begin : stream_monitor
		bdph_pkg::out_item_t got;
		bdph_pkg::out_item_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				flags_due.push_back(debounce_step(s_axis_tuser, s_axis_tdata[1:0],
					s_axis_tdata[2]));
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got = m_axis_tdata[4:0];
				if (flags_due.size() == 0) begin
					report_mismatch("result with nothing pending, tdata", m_axis_tdata, 0);
				end else begin
					want = flags_due.pop_front();
					if (got.result_bit !== want.result_bit)
						report_mismatch("result_bit", got.result_bit, want.result_bit);
					if (got.held_flags !== want.held_flags)
						report_mismatch("held_flags", got.held_flags, want.held_flags);
					if (got.pressed_flags !== want.pressed_flags)
						report_mismatch("pressed_flags", got.pressed_flags, want.pressed_flags);
					if (m_axis_tdata[7:5] !== 3'b000)
						report_mismatch("tdata padding", m_axis_tdata[7:5], 0);
				end
			end
		end
	end

	// Output-side driver. While idling is allowed it drives bursts of ready or stall, picked at
	// random, and it honors a long hold-off on request, counting it down here.
	initial begin : result_sink
		int burst_left;
		int hold_left;
		bit ready_val;
		burst_left = 0;
		hold_left  = 0;
		ready_val  = 1'b1;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_request > 0) begin
				hold_left       = rx_hold_request;
				rx_hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				if (burst_left == 0) begin
					ready_val  = !(rx_idle_en && $urandom_range(0, 2) == 0);
					burst_left = $urandom_range(1, 16);
				end
				burst_left--;
				m_axis_tready <= ready_val;
			end
		end
	end

	// Offers one transaction and returns at the edge where it is taken. Valid stays high into the
	// next call unless an idle burst follows.
	task automatic send_item(input logic [1:0] mode, input logic [1:0] sense, input logic idx);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= mode;
		s_axis_tdata  <= {5'b00000, idx, sense};
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		if (tx_idle_en && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
	endtask

	// Drops valid and waits until every result has come back, plus a short margin, so the block
	// is idle afterwards.
	task automatic settle_idle();
		s_axis_tvalid <= 1'b0;
		while (results_seen != items_sent)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// APB write followed by a read-back of the same register. The shadow copy changes at the
	// edge where the write completes.
	task automatic write_reg(input logic [1:0] idx, input logic [bdph_pkg::TIMER_W-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {{(bdph_pkg::CFG_DATA_W - bdph_pkg::TIMER_W){1'b0}}, value};
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		case (idx)
			bdph_pkg::REG_HOLD_TIME:  cfg_hold_time  = value;
			bdph_pkg::REG_TICK_STEP:  cfg_tick_step  = value;
			bdph_pkg::REG_PRESS_TIME: cfg_press_time = value;
			default: begin
			end
		endcase
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		if (prdata !== {{(bdph_pkg::CFG_DATA_W - bdph_pkg::TIMER_W){1'b0}}, value})
			report_mismatch("register read-back", prdata, value);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_all_regs(input logic [bdph_pkg::TIMER_W-1:0] hold,
		input logic [bdph_pkg::TIMER_W-1:0] step, input logic [bdph_pkg::TIMER_W-1:0] press);
		write_reg(bdph_pkg::REG_HOLD_TIME, hold);
		write_reg(bdph_pkg::REG_TICK_STEP, step);
		write_reg(bdph_pkg::REG_PRESS_TIME, press);
	endtask

	// A threshold for a random phase: mostly small so that presses and holds are reached in a
	// few ticks, now and then one of the two extremes.
	function automatic logic [bdph_pkg::TIMER_W-1:0] pick_threshold();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 16'hFFFF;
		return 16'($urandom_range(0, 300));
	endfunction

	// Reset values: six ticks of 10 push button 0 past the press time of 50. The press is
	// reported once, the second read answers 0, and the release clears the acknowledged press.
	task automatic test_reset_defaults();
		repeat (6) send_item(bdph_pkg::MODE_TICK, 2'b01, 1'b0);
		send_item(bdph_pkg::MODE_READ_PRESS, 2'b00, 1'b0);
		send_item(bdph_pkg::MODE_READ_PRESS, 2'b00, 1'b0);
		send_item(bdph_pkg::MODE_READ_PRESS, 2'b11, 1'b1);
		send_item(bdph_pkg::MODE_READ_HELD, 2'b00, 1'b0);
		send_item(bdph_pkg::MODE_TICK, 2'b00, 1'b0);
		settle_idle();
	endtask

	// Largest step and hold time: the first tick takes both timers to the top value, which is
	// just above the press time; the next tick finds the hold time reached. The unused mode
	// must leave all of it alone.
	task automatic test_extremes();
		write_all_regs(16'hFFFF, 16'hFFFF, 16'hFFFE);
		send_item(bdph_pkg::MODE_TICK, 2'b11, 1'b0);
		send_item(bdph_pkg::MODE_TICK, 2'b11, 1'b1);
		send_item(bdph_pkg::MODE_READ_HELD, 2'b00, 1'b1);
		send_item(MODE_UNUSED, 2'b11, 1'b1);
		send_item(bdph_pkg::MODE_READ_PRESS, 2'b11, 1'b1);
		send_item(bdph_pkg::MODE_TICK, 2'b00, 1'b0);
		settle_idle();
	endtask

	// Zero hold time: a sensed button is held at once and its timer stays at zero, so a press
	// time of zero is never exceeded.
	task automatic test_zero_hold();
		write_all_regs(16'd0, 16'd0, 16'd0);
		send_item(bdph_pkg::MODE_TICK, 2'b10, 1'b0);
		send_item(bdph_pkg::MODE_READ_HELD, 2'b01, 1'b1);
		send_item(bdph_pkg::MODE_READ_HELD, 2'b10, 1'b0);
		send_item(bdph_pkg::MODE_TICK, 2'b00, 1'b1);
		settle_idle();
	endtask

	// Random traffic under a fresh random setting. Each button follows a level that changes
	// only now and then, so presses last long enough to latch and to reach the hold time; a
	// few ticks carry glitches on top. Reads ask about either button. Unused-mode items are
	// mixed in but do not count toward the total.
	task automatic test_random_phase(input int count);
		logic [1:0] level;
		logic [1:0] sense;
		int         done;
		int         r;
		level = '0;
		done  = 0;
		write_all_regs(pick_threshold(),
			($urandom_range(0, 9) == 0) ? 16'hFFFF : 16'($urandom_range(0, 80)),
			pick_threshold());
		while (done < count) begin
			r = $urandom_range(0, 99);
			if (r < 58) begin
				for (int b = 0; b < N_BTN; b++)
					if ($urandom_range(0, 13) == 0)
						level[b] = ~level[b];
				sense = level;
				if ($urandom_range(0, 19) == 0)
					sense ^= 2'($urandom_range(1, 3));
				send_item(bdph_pkg::MODE_TICK, sense, 1'($urandom));
				done++;
			end else if (r < 76) begin
				send_item(bdph_pkg::MODE_READ_PRESS, 2'($urandom), 1'($urandom));
				done++;
			end else if (r < 93) begin
				send_item(bdph_pkg::MODE_READ_HELD, 2'($urandom), 1'($urandom));
				done++;
			end else begin
				send_item(MODE_UNUSED, 2'($urandom), 1'($urandom));
			end
		end
		settle_idle();
	endtask

	// The output side holds off for a long stretch while items keep coming back to back. The
	// two result slots fill, the input stalls, and everything must drain in order afterwards.
	task automatic test_output_backpressure();
		tx_idle_en      = 1'b0;
		rx_hold_request = 80;
		for (int k = 0; k < 24; k++)
			send_item(bdph_pkg::mode_t'($urandom_range(0, 2)), 2'($urandom), 1'($urandom));
		settle_idle();
		tx_idle_en = 1'b1;
	endtask

	initial begin
		// Every input gets a known value before the first edge.
		arst_n        <= 1'b0;
		psel          <= 1'b0;
		penable       <= 1'b0;
		pwrite        <= 1'b0;
		paddr         <= '0;
		pwdata        <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tuser  <= '0;
		s_axis_tdata  <= '0;
		tx_idle_en      = 1'b1;
		rx_idle_en      = 1'b1;
		rx_hold_request = 0;
		items_sent      = 0;
		results_seen    = 0;
		mismatch_count  = 0;

		// The shadow starts from the reset state of the block.
		cfg_hold_time  = bdph_pkg::HOLD_TIME_RST;
		cfg_tick_step  = bdph_pkg::TICK_STEP_RST;
		cfg_press_time = bdph_pkg::PRESS_TIME_RST;
		for (int b = 0; b < N_BTN; b++) begin
			btn_timer[b] = '0;
			btn_held[b]  = 1'b0;
			btn_press[b] = 1'b0;
			btn_acked[b] = 1'b0;
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_extremes();
		test_zero_hold();
		for (int p = 0; p < 6; p++)
			test_random_phase(100);
		test_output_backpressure();

		// The closing stretch runs with both sides always willing.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		test_random_phase(90);

		if (mismatch_count == 0 && flags_due.size() == 0) begin
			$display("PASS button_debounce_press_hold_unit");
		end else begin
			$display("FAIL button_debounce_press_hold_unit");
		end
		$finish;
	end

endmodule

>>> button_debounce_press_hold_unit.f
+incdir+hw/rtl
hw/rtl/bdph_pkg.sv
hw/rtl/bdph_lane.sv
hw/rtl/bdph_merge.sv
hw/rtl/bdph_out_buf.sv
hw/rtl/button_debounce_press_hold_unit.sv
tb/tb_button_debounce_press_hold_unit.sv
